### hw/rtl/spx_pkg.sv
`timescale 1ns / 1ps
package spx_pkg;

  localparam int COL_W       = 10;
  localparam int CNT_W       = 17;
  localparam int ROW_W       = 16;
  localparam int VAL_W       = 64;
  localparam int CFG_W       = 17;
  localparam int MAX_ENTRIES = 65536;
  localparam int EPOCH_W     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_MAP   = 2'd1,
    OP_NZ    = 2'd2,
    OP_EOR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_ROWPTR = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_COLUMN  = 2'd1,
    ERR_STORAGE = 2'd2,
    ERR_ROW     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CFG_SRC_COLS    = 2'd0,
    CFG_SRC_ROWS    = 2'd1,
    CFG_TGT_COLS    = 2'd2,
    CFG_STORE_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0]      src_cols;
    logic [16:0]      src_rows;
    logic [10:0]      tgt_cols;
    logic [CNT_W-1:0] store_limit;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             bad;
    logic [COL_W-1:0] scol;
    logic [COL_W-1:0] tcol;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [COL_W-1:0]   tcol;
  } map_ent_t;

endpackage

### hw/rtl/spx_front.sv
`timescale 1ns / 1ps
module spx_front #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [spx_pkg::COL_W-1:0]        in_source_column,
  input  logic [spx_pkg::COL_W-1:0]        in_target_column,
  input  logic [spx_pkg::VAL_W-1:0]        in_entry_value,
  input  logic [spx_pkg::ROW_W-1:0]        in_source_row,
  input  spx_pkg::cfg_t                    cfg,
  output logic                             push_valid,
  input  logic                             push_ready,
  output spx_pkg::item_t                   push_item
);

  logic col_ok;
  logic tcol_ok;
  logic row_ok;
  spx_pkg::op_t op;

  assign op = spx_pkg::op_t'(in_opcode);

  assign col_ok  = ({1'b0, in_source_column} < cfg.src_cols) &&
                   ({22'd0, in_source_column} < 32'(MAX_COLUMNS));
  assign tcol_ok = {1'b0, in_target_column} < cfg.tgt_cols;
  assign row_ok  = {1'b0, in_source_row} < cfg.src_rows;

  always_comb begin
    push_item.op    = op;
    push_item.scol  = in_source_column;
    push_item.tcol  = in_target_column;
    push_item.value = in_entry_value;
    case (op)
      spx_pkg::OP_START: push_item.bad = 1'b0;
      spx_pkg::OP_MAP:   push_item.bad = !(col_ok && tcol_ok);
      spx_pkg::OP_NZ:    push_item.bad = !col_ok;
      spx_pkg::OP_EOR:   push_item.bad = !row_ok;
      default:           push_item.bad = 1'b0;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

### hw/rtl/spx_queue.sv
`timescale 1ns / 1ps
module spx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  spx_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output spx_pkg::item_t pop_item
);

  localparam int PW = spx_pkg::QPTR_W;

  spx_pkg::item_t slot_r [spx_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [PW:0]    fill_r, fill_nxt;
  logic           push;
  logic           pop;

  assign push_ready = fill_r != (PW + 1)'(spx_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(spx_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(spx_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/spx_back.sv
`timescale 1ns / 1ps
module spx_back #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spx_pkg::cfg_t               cfg,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  spx_pkg::item_t              pop_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [spx_pkg::CNT_W-1:0]   out_position,
  output logic [spx_pkg::COL_W-1:0]   out_new_column,
  output logic [spx_pkg::VAL_W-1:0]   out_out_value,
  output logic [1:0]                  out_error_code
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EW = spx_pkg::EPOCH_W;

  // column map, tagged with the job epoch that wrote it
  spx_pkg::map_ent_t map_mem [MAX_COLUMNS];
  spx_pkg::map_ent_t rd_r;

  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  spx_pkg::map_ent_t mem_wdata;
  logic [CW-1:0]     mem_raddr;

  logic              clr_active_r, clr_active_nxt;
  logic [CW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [EW-1:0]     epoch_r, epoch_nxt;

  logic              b_valid_r, b_valid_nxt;
  spx_pkg::item_t    b_item_r;
  logic [EW-1:0]     b_epoch_r;
  logic              b_adv;
  logic              pop;

  logic [spx_pkg::CNT_W-1:0] count_r, count_nxt;

  logic                      res_valid;
  spx_pkg::kind_t            res_kind;
  logic [spx_pkg::CNT_W-1:0] res_pos;
  logic [spx_pkg::COL_W-1:0] res_col;
  logic [spx_pkg::VAL_W-1:0] res_val;
  spx_pkg::err_t             res_err;

  logic                      out_valid_r, out_valid_nxt;
  spx_pkg::kind_t            out_kind_r;
  logic [spx_pkg::CNT_W-1:0] out_pos_r;
  logic [spx_pkg::COL_W-1:0] out_col_r;
  logic [spx_pkg::VAL_W-1:0] out_val_r;
  spx_pkg::err_t             out_err_r;

  logic hit;
  logic col_live;
  logic store_full;

  assign b_adv     = b_valid_r && (!out_valid_r || out_ready);
  assign pop_ready = !clr_active_r && (!b_valid_r || b_adv);
  assign pop       = pop_valid && pop_ready;

  assign mem_raddr = CW'(pop_item.scol);
  assign mem_we    = clr_active_r ||
                     (pop && pop_item.op == spx_pkg::OP_MAP && !pop_item.bad);
  assign mem_waddr = clr_active_r ? clr_addr_r : CW'(pop_item.scol);

  always_comb begin
    mem_wdata = '0;
    if (!clr_active_r) begin
      mem_wdata.tag  = epoch_r;
      mem_wdata.tcol = pop_item.tcol;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_r <= map_mem[mem_raddr];
    end
  end

  // epoch zero marks a cleared entry, so a wrap forces a clearing pass
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_COLUMNS - 1)) begin
        clr_active_nxt = 1'b0;
        clr_addr_nxt   = '0;
      end
    end else if (pop && pop_item.op == spx_pkg::OP_START) begin
      if (epoch_r == '1) begin
        epoch_nxt      = EW'(1);
        clr_active_nxt = 1'b1;
        clr_addr_nxt   = '0;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (pop) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r  <= pop_item;
      b_epoch_r <= epoch_r;
    end
  end

  assign hit        = rd_r.tag == b_epoch_r;
  assign col_live   = {1'b0, rd_r.tcol} < cfg.tgt_cols;
  assign store_full = (count_r >= cfg.store_limit) ||
                      (32'(count_r) >= spx_pkg::MAX_ENTRIES);

  always_comb begin
    res_valid = 1'b0;
    res_kind  = spx_pkg::KIND_ERROR;
    res_pos   = '0;
    res_col   = '0;
    res_val   = '0;
    res_err   = spx_pkg::ERR_NONE;
    count_nxt = count_r;
    case (b_item_r.op)
      spx_pkg::OP_START: begin
        res_valid = 1'b1;
        res_kind  = spx_pkg::KIND_ROWPTR;
        count_nxt = '0;
      end
      spx_pkg::OP_MAP: begin
        if (b_item_r.bad) begin
          res_valid = 1'b1;
          res_err   = spx_pkg::ERR_COLUMN;
        end
      end
      spx_pkg::OP_NZ: begin
        if (b_item_r.bad) begin
          res_valid = 1'b1;
          res_err   = spx_pkg::ERR_COLUMN;
        end else if (hit && col_live) begin
          res_valid = 1'b1;
          if (store_full) begin
            res_err = spx_pkg::ERR_STORAGE;
          end else begin
            res_kind  = spx_pkg::KIND_ENTRY;
            res_pos   = count_r;
            res_col   = rd_r.tcol;
            res_val   = b_item_r.value;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      spx_pkg::OP_EOR: begin
        res_valid = 1'b1;
        if (b_item_r.bad) begin
          res_err = spx_pkg::ERR_ROW;
        end else begin
          res_kind = spx_pkg::KIND_ROWPTR;
          res_pos  = count_r;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (b_adv && res_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      epoch_r      <= EW'(1);
      b_valid_r    <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      b_valid_r    <= b_valid_nxt;
      if (b_adv) begin
        count_r <= count_nxt;
      end
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && res_valid) begin
      out_kind_r <= res_kind;
      out_pos_r  <= res_pos;
      out_col_r  <= res_col;
      out_val_r  <= res_val;
      out_err_r  <= res_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_position    = out_pos_r;
  assign out_new_column  = out_col_r;
  assign out_out_value   = out_val_r;
  assign out_error_code  = out_err_r;

endmodule

### hw/rtl/sparse_row_submatrix_extract.sv
`timescale 1ns / 1ps
// Builds the compressed-sparse-row form of a column-remapped row subset from a beat stream of
// start, map-write, nonzero and end-of-row items, at one item per clock sustained when the
// result side keeps up and no clearing pass runs; the rate is set by the column map memory,
// which does one read and one write per cycle. An item's result passes through a queue slot,
// the map lookup and the output register before it can be taken.
// After reset, and again after every fifteenth start item, the map is swept by a clearing
// pass over all MAX_COLUMNS entries, during which the input side takes at most four further
// beats; configuration writes are taken at any time.
module sparse_row_submatrix_extract #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [spx_pkg::COL_W-1:0]   in_source_column,
  input  logic [spx_pkg::COL_W-1:0]   in_target_column,
  input  logic [spx_pkg::VAL_W-1:0]   in_entry_value,
  input  logic [spx_pkg::ROW_W-1:0]   in_source_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [spx_pkg::CNT_W-1:0]   out_position,
  output logic [spx_pkg::COL_W-1:0]   out_new_column,
  output logic [spx_pkg::VAL_W-1:0]   out_out_value,
  output logic [1:0]                  out_error_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [spx_pkg::CFG_W-1:0]   cfg_data
);

  spx_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           push_valid;
  logic           push_ready;
  spx_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  spx_pkg::item_t pop_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (spx_pkg::cfg_idx_t'(cfg_index))
        spx_pkg::CFG_SRC_COLS:    cfg_nxt.src_cols    = cfg_data[10:0];
        spx_pkg::CFG_SRC_ROWS:    cfg_nxt.src_rows    = cfg_data;
        spx_pkg::CFG_TGT_COLS:    cfg_nxt.tgt_cols    = cfg_data[10:0];
        spx_pkg::CFG_STORE_LIMIT: cfg_nxt.store_limit = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_cols    <= 11'd1024;
      cfg_r.src_rows    <= 17'd65536;
      cfg_r.tgt_cols    <= 11'd1024;
      cfg_r.store_limit <= 17'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spx_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_source_column (in_source_column),
    .in_target_column (in_target_column),
    .in_entry_value   (in_entry_value),
    .in_source_row    (in_source_row),
    .cfg              (cfg_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  spx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  spx_back #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_position    (out_position),
    .out_new_column  (out_new_column),
    .out_out_value   (out_out_value),
    .out_error_code  (out_error_code)
  );

endmodule

### hw/rtl/spx_checker.sv
`timescale 1ns / 1ps
module spx_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_result_kind,
  input logic [spx_pkg::CNT_W-1:0]   out_position,
  input logic [spx_pkg::COL_W-1:0]   out_new_column,
  input logic [spx_pkg::VAL_W-1:0]   out_out_value,
  input logic [1:0]                  out_error_code
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_position) && $stable(out_new_column) && $stable(out_out_value) &&
      $stable(out_error_code))
    else $error("result beat changed while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == spx_pkg::KIND_ERROR |->
      out_position == '0 && out_new_column == '0 && out_out_value == '0 &&
      out_error_code != spx_pkg::ERR_NONE)
    else $error("error beat carries payload or no code");

  a_rowptr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == spx_pkg::KIND_ROWPTR |->
      out_error_code == spx_pkg::ERR_NONE && out_new_column == '0 && out_out_value == '0)
    else $error("row pointer beat carries entry fields");

  a_entry_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == spx_pkg::KIND_ENTRY |->
      out_error_code == spx_pkg::ERR_NONE &&
      32'(out_position) < spx_pkg::MAX_ENTRIES)
    else $error("entry beat beyond storage");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind != 2'd3)
    else $error("undefined result kind");

endmodule

bind sparse_row_submatrix_extract spx_checker u_spx_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps

typedef struct {
  spx_pkg::kind_t                 kind;
  logic [spx_pkg::CNT_W-1:0]      pos;
  logic [spx_pkg::COL_W-1:0]      col;
  logic [spx_pkg::VAL_W-1:0]      val;
  spx_pkg::err_t                  err;
} csr_beat_t;

class csr_tracker;
  int unsigned src_cols;
  int unsigned src_rows;
  int unsigned tgt_cols;
  int unsigned store_limit;
  bit [spx_pkg::COL_W-1:0] col_map [1024];
  bit map_set [1024];
  int unsigned emitted;
  csr_beat_t due [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned n_kind [4];
  int unsigned n_err [4];

  function new();
    src_cols = 1024;
    src_rows = 65536;
    tgt_cols = 1024;
    store_limit = 65536;
    emitted = 0;
    foreach (map_set[i]) begin
      map_set[i] = 1'b0;
      col_map[i] = '0;
    end
  endfunction

  function void set_reg(spx_pkg::cfg_idx_t idx, int unsigned value);
    case (idx)
      spx_pkg::CFG_SRC_COLS:    src_cols = value & 'h7FF;
      spx_pkg::CFG_SRC_ROWS:    src_rows = value & 'h1FFFF;
      spx_pkg::CFG_TGT_COLS:    tgt_cols = value & 'h7FF;
      spx_pkg::CFG_STORE_LIMIT: store_limit = value & 'h1FFFF;
      default: ;
    endcase
  endfunction

  function void push_error(spx_pkg::err_t code);
    csr_beat_t r;
    r = '{kind: spx_pkg::KIND_ERROR, pos: '0, col: '0, val: '0, err: code};
    due.push_back(r);
  endfunction

  function void take_item(spx_pkg::op_t op, logic [9:0] scol, logic [9:0] tcol,
                          logic [63:0] val, logic [15:0] row);
    csr_beat_t r;
    r = '{kind: spx_pkg::KIND_ROWPTR, pos: '0, col: '0, val: '0, err: spx_pkg::ERR_NONE};
    case (op)
      spx_pkg::OP_START: begin
        foreach (map_set[i]) map_set[i] = 1'b0;
        emitted = 0;
        due.push_back(r);
      end
      spx_pkg::OP_MAP: begin
        if (scol >= src_cols || tcol >= tgt_cols) begin
          push_error(spx_pkg::ERR_COLUMN);
        end else begin
          col_map[scol] = tcol;
          map_set[scol] = 1'b1;
        end
      end
      spx_pkg::OP_NZ: begin
        if (scol >= src_cols) begin
          push_error(spx_pkg::ERR_COLUMN);
        end else if (map_set[scol] && col_map[scol] < tgt_cols) begin
          if (emitted >= store_limit || emitted >= spx_pkg::MAX_ENTRIES) begin
            push_error(spx_pkg::ERR_STORAGE);
          end else begin
            r.kind = spx_pkg::KIND_ENTRY;
            r.pos = emitted[spx_pkg::CNT_W-1:0];
            r.col = col_map[scol];
            r.val = val;
            due.push_back(r);
            emitted = (emitted + 1) & 'h1FFFF;
          end
        end
      end
      default: begin
        if (row >= src_rows) begin
          push_error(spx_pkg::ERR_ROW);
        end else begin
          r.pos = emitted[spx_pkg::CNT_W-1:0];
          due.push_back(r);
        end
      end
    endcase
  endfunction

  function void match_result(logic [1:0] kind, logic [16:0] pos, logic [9:0] col,
                             logic [63:0] val, logic [1:0] err);
    csr_beat_t want;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: kind=%0d pos=%0d col=%0d val=%h err=%0d",
                 kind, pos, col, val, err);
      return;
    end
    want = due.pop_front();
    checked++;
    n_kind[want.kind]++;
    n_err[want.err]++;
    if (kind !== want.kind || pos !== want.pos || col !== want.col ||
        val !== want.val || err !== want.err) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected kind=%0d pos=%0d col=%0d val=%h err=%0d",
                 int'(want.kind), want.pos, want.col, want.val, int'(want.err));
        $display("          actual   kind=%0d pos=%0d col=%0d val=%h err=%0d",
                 kind, pos, col, val, err);
      end
    end
  endfunction
endclass

module tb;

  localparam int SETTLE       = 1100;
  localparam int WATCHDOG     = 20000;
  localparam int HOLD         = 300;
  localparam int RANDOM_ITEMS = 1000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   in_opcode;
  logic [spx_pkg::COL_W-1:0]    in_source_column;
  logic [spx_pkg::COL_W-1:0]    in_target_column;
  logic [spx_pkg::VAL_W-1:0]    in_entry_value;
  logic [spx_pkg::ROW_W-1:0]    in_source_row;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   out_result_kind;
  logic [spx_pkg::CNT_W-1:0]    out_position;
  logic [spx_pkg::COL_W-1:0]    out_new_column;
  logic [spx_pkg::VAL_W-1:0]    out_out_value;
  logic [1:0]                   out_error_code;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index;
  logic [spx_pkg::CFG_W-1:0]    cfg_data;

  csr_tracker  csr;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned settings;

  sparse_row_submatrix_extract dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_source_column (in_source_column),
    .in_target_column (in_target_column),
    .in_entry_value   (in_entry_value),
    .in_source_row    (in_source_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_position     (out_position),
    .out_new_column   (out_new_column),
    .out_out_value    (out_out_value),
    .out_error_code   (out_error_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [9:0] pick_col();
    if ($urandom_range(0, 11) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, csr.src_cols - 1));
  endfunction

  function automatic logic [9:0] pick_tgt();
    if (csr.tgt_cols == 0 || $urandom_range(0, 11) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, csr.tgt_cols - 1));
  endfunction

  function automatic logic [15:0] pick_row();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, (csr.src_rows > 65536 ? 65536 : csr.src_rows) - 1));
  endfunction

  task automatic send_item(spx_pkg::op_t op, logic [9:0] scol, logic [9:0] tcol,
                           logic [63:0] val, logic [15:0] row);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_source_column <= scol;
    in_target_column <= tcol;
    in_entry_value   <= val;
    in_source_row    <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    csr.take_item(op, scol, tcol, val, row);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_noise();
    send_item(spx_pkg::op_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
              10'($urandom_range(0, 1023)), rand64(), 16'($urandom_range(0, 65535)));
  endtask

  // drain everything, then cover a possible map clearing pass before touching registers
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (csr.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(spx_pkg::cfg_idx_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[spx_pkg::CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    csr.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned scols, int unsigned srows, int unsigned tcols,
                           int unsigned slimit);
    write_reg(spx_pkg::CFG_SRC_COLS, scols);
    write_reg(spx_pkg::CFG_SRC_ROWS, srows);
    write_reg(spx_pkg::CFG_TGT_COLS, tcols);
    write_reg(spx_pkg::CFG_STORE_LIMIT, slimit);
    settings++;
  endtask

  task automatic random_job(bit fresh);
    logic [9:0] mapped [$];
    logic [9:0] c;
    if (fresh) send_item(spx_pkg::OP_START, pick_col(), pick_tgt(), rand64(), pick_row());
    repeat ($urandom_range(1, 12)) begin
      c = pick_col();
      send_item(spx_pkg::OP_MAP, c, pick_tgt(), rand64(), 16'($urandom_range(0, 65535)));
      mapped.push_back(c);
    end
    repeat ($urandom_range(1, 5)) begin
      repeat ($urandom_range(0, 8)) begin
        if (mapped.size() != 0 && $urandom_range(0, 9) < 7)
          c = mapped[$urandom_range(0, mapped.size() - 1)];
        else
          c = pick_col();
        send_item(spx_pkg::OP_NZ, c, 10'($urandom_range(0, 1023)), rand64(),
                  16'($urandom_range(0, 65535)));
      end
      send_item(spx_pkg::OP_EOR, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                rand64(), pick_row());
      if ($urandom_range(0, 9) == 0) send_noise();
    end
  endtask

  task automatic random_settings();
    int unsigned sc, sr, tc, sl;
    case ($urandom_range(0, 3))
      0: sc = 1024;
      1: sc = $urandom_range(1, 16);
      default: sc = $urandom_range(1, 1024);
    endcase
    case ($urandom_range(0, 3))
      0: sr = 65536;
      1: sr = 1;
      default: sr = $urandom_range(1, 65536);
    endcase
    case ($urandom_range(0, 7))
      0: tc = 0;
      1, 2: tc = 1024;
      default: tc = $urandom_range(1, 1024);
    endcase
    case ($urandom_range(0, 3))
      0: sl = 65536;
      1: sl = $urandom_range(0, 30);
      default: sl = $urandom_range(0, 65536);
    endcase
    configure(sc, sr, tc, sl);
  endtask

  // result side: stall pattern of its own plus one long hold-off
  initial begin
    int unsigned mode, mode_left;
    bit held;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        csr.match_result(out_result_kind, out_position, out_new_column, out_out_value,
                         out_error_code);
      if (!held && csr.checked >= 200 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet, csr.due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned base;
    bit opening;
    csr = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_source_column = '0;
    in_target_column = '0;
    in_entry_value = '0;
    in_source_row = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    settings = 0;
    burst_left = 4;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, items ahead of any start
    send_item(spx_pkg::OP_NZ, 10'd5, 10'd0, 64'h1, 16'd0);
    send_item(spx_pkg::OP_EOR, 10'd0, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd5, 10'd7, 64'd0, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd5, 10'd0, '1, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd5, 10'd1023, 64'd0, 16'hFFFF);
    send_item(spx_pkg::OP_NZ, 10'd5, 10'd1023, 64'd0, 16'd0);
    send_item(spx_pkg::OP_EOR, 10'd1023, 10'd1023, 64'd0, 16'hFFFF);
    send_item(spx_pkg::OP_START, 10'd0, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd5, 10'd0, 64'h2, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd1023, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd1023, 10'd0, 64'h5555_5555_aaaa_aaaa, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd0, 10'd0, 64'h3, 16'd0);

    // narrow matrix: column, row and storage errors
    quiesce();
    configure(8, 1, 4, 2);
    send_item(spx_pkg::OP_START, 10'd0, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd8, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd2, 10'd4, 64'd0, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd2, 10'd3, 64'd0, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd1023, 10'd0, 64'd4, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd2, 10'd0, 64'hdead_beef_0123_4567, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd2, 10'd0, 64'h8000_0000_0000_0001, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd2, 10'd0, 64'd5, 16'd0);
    send_item(spx_pkg::OP_EOR, 10'd0, 10'd0, 64'd0, 16'd1);
    send_item(spx_pkg::OP_EOR, 10'd0, 10'd0, 64'd0, 16'd0);

    // shrink the target width under a live map, no storage left
    quiesce();
    write_reg(spx_pkg::CFG_TGT_COLS, 3);
    write_reg(spx_pkg::CFG_STORE_LIMIT, 0);
    send_item(spx_pkg::OP_NZ, 10'd2, 10'd0, 64'd6, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd0, 10'd2, 64'd0, 16'd0);
    send_item(spx_pkg::OP_NZ, 10'd0, 10'd0, 64'd7, 16'd0);

    // single source column, empty target
    quiesce();
    write_reg(spx_pkg::CFG_SRC_COLS, 1);
    write_reg(spx_pkg::CFG_TGT_COLS, 0);
    send_item(spx_pkg::OP_MAP, 10'd0, 10'd0, 64'd0, 16'd0);
    send_item(spx_pkg::OP_MAP, 10'd1, 10'd0, 64'd0, 16'd0);

    base = items_sent;
    opening = 1'b1;
    while (items_sent - base < RANDOM_ITEMS) begin
      quiesce();
      if (opening) configure(1024, 65536, 1024, 65536);
      else random_settings();
      random_job(opening || $urandom_range(0, 2) != 0);
      opening = 1'b0;
      repeat ($urandom_range(1, 3)) random_job(1'b1);
      if ($urandom_range(0, 3) == 0) send_noise();
    end
    quiesce();

    $display("ran %0d items under %0d register settings, %0d result beats checked",
             items_sent, settings, csr.checked);
    $display("entries %0d, row pointers %0d, errors: column %0d storage %0d row %0d",
             csr.n_kind[spx_pkg::KIND_ENTRY], csr.n_kind[spx_pkg::KIND_ROWPTR],
             csr.n_err[spx_pkg::ERR_COLUMN], csr.n_err[spx_pkg::ERR_STORAGE],
             csr.n_err[spx_pkg::ERR_ROW]);
    if (csr.mismatches == 0 && csr.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", csr.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
